/* sv/pkmeg_pkg.sv */
// Package for the pedal key MIDI event generator: register indexes, event
// codes, FSM state type, divider step count and the automatic velocity table.
// No dependencies.
`default_nettype none

package pkmeg_pkg;

  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [63:0] VEL_RATIO_Q32 = 64'd4179117881;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOTE_ON      = 3'd0,
    REG_NOTE_OFF     = 3'd1,
    REG_PRESS_LEVEL  = 3'd2,
    REG_PRESS_DEPTH  = 3'd3,
    REG_VELOCITY     = 3'd4,
    REG_PRESS_MODE   = 3'd5,
    REG_CHANNEL      = 3'd6,
    REG_OCTAVE       = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    EV_NOTE_ON    = 2'd0,
    EV_NOTE_OFF   = 2'd1,
    EV_CHAN_PRESS = 2'd2,
    EV_POLY_PRESS = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    PM_OFF     = 2'd0,
    PM_CHANNEL = 2'd1,
    PM_POLY    = 2'd2,
    PM_OFF_ALT = 2'd3
  } press_mode_e;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_CALIB  = 1'b1;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_RD    = 10'b00_0000_0010,
    ST_LVL   = 10'b00_0000_0100,
    ST_DIVL  = 10'b00_0000_1000,
    ST_EVAL  = 10'b00_0001_0000,
    ST_DIVP  = 10'b00_0010_0000,
    ST_MULA  = 10'b00_0100_0000,
    ST_MULB  = 10'b00_1000_0000,
    ST_EMIT0 = 10'b01_0000_0000,
    ST_EMIT1 = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic [15:0] note_on;
    logic [15:0] note_off;
    logic [15:0] press_level;
    logic [15:0] press_depth;
    logic [7:0]  velocity;
    logic [1:0]  press_mode;
    logic [4:0]  channel;
    logic [3:0]  octave;
  } cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] note;
    logic [6:0] value;
  } event_t;

  typedef logic [255:0][6:0] vel_table_t;

  function automatic vel_table_t build_vel();
    logic [63:0] p;
    logic [63:0] t;
    vel_table_t  tb;
    p = 64'h1_0000_0000;
    for (int i = 0; i < 256; i++) begin
      t     = 64'd127 * (64'h1_0000_0000 - p) + 64'h8000_0000;
      tb[i] = t[38:32];
      p     = (p * VEL_RATIO_Q32 + 64'h8000_0000) >> 32;
    end
    return tb;
  endfunction

  localparam vel_table_t VEL_TABLE = build_vel();

endpackage

`default_nettype wire

/* sv/pkmeg_div.sv */
// Restoring divider, one quotient bit per cycle: quot = (rem << 16) / div,
// valid for rem < div. Depends on pkmeg_pkg for the step count.
`default_nettype none

module pkmeg_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [16:0] rem_i,
  input  wire logic [16:0] div_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [15:0]      quot_o
);

  localparam int unsigned CW = $clog2(pkmeg_pkg::DIV_STEPS);
  localparam logic [CW-1:0] LAST = CW'(pkmeg_pkg::DIV_STEPS - 1);

  logic [16:0]   rem_q, div_q;
  logic [15:0]   quot_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [17:0]   shl, diff;
  logic          ge;

  always_comb begin
    shl  = {rem_q, 1'b0};
    ge   = shl >= {1'b0, div_q};
    diff = shl - {1'b0, div_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= rem_i;
      div_q <= div_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[16:0] : shl[16:0];
      quot_q <= {quot_q[14:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

/* sv/pedal_key_midi_event_generator.sv */
// Pedal key MIDI event generator top level: key state memories, sequencer,
// output register. Depends on pkmeg_pkg and pkmeg_div.
//
// Input channel (in_valid_i / in_stall_o): one item per transfer, either a
// key sample or a calibration write. Output channel (out_valid_o /
// out_stall_i): zero to two events per sample, last_event_o marks the final.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_index_i.
// A calibration write or an out-of-range key is done without leaving idle.
// A sample with its value between the bounds runs the 16-step level divider;
// aftertouch runs the same divider and the two-stage scaling multiply.
// Per-key state sits in two synchronous memories read once per sample; note
// state is written back once, and the next item is taken only after that.
// Reset: registers take their defaults, all keys read as silent with level
// zero and bounds 0..1024 via per-entry valid bits; no clearing pass.
// A stalled receiver holds the output register; the sequencer waits in its
// emit states, taking no new item there, and may take one once back in idle.
`default_nettype none

module pedal_key_midi_event_generator #(
  parameter int unsigned KEY_COUNT   = 32,
  parameter int unsigned SENSOR_BITS = 10
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic                                  command_i,
  input  wire logic [4:0]                            key_index_i,
  input  wire logic [SENSOR_BITS-1:0]                sample_value_i,
  input  wire logic [10:0]                           bound_low_i,
  input  wire logic [10:0]                           bound_high_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [1:0]                                 event_kind_o,
  output logic [4:0]                                 event_channel_o,
  output logic [6:0]                                 note_number_o,
  output logic [6:0]                                 event_value_o,
  output logic                                       last_event_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [pkmeg_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire logic [pkmeg_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned KW = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int unsigned VW = (SENSOR_BITS > 11) ? SENSOR_BITS : 11;

  pkmeg_pkg::cfg_t   cfg_q;
  pkmeg_pkg::state_e state_q, state_d;

  logic [16:0] note_mem [KEY_COUNT];
  logic [21:0] cal_mem  [KEY_COUNT];
  logic [KEY_COUNT-1:0] note_vld_q, cal_vld_q;

  logic [16:0] note_rd_q;
  logic [21:0] cal_rd_q;
  logic        note_rd_vld_q, cal_rd_vld_q;
  logic [KW-1:0] idx_q;
  logic [4:0]  key_q;
  logic [VW-1:0] v_q;
  logic [15:0] lvl_q;
  logic        on_q, off_q, pt_q;
  logic [6:0]  vel_q, amt_q;
  logic [31:0] prod1_q;

  logic          accept, key_ok;
  logic [KW-1:0] in_idx;
  logic [10:0]   lo, hi;
  logic [VW-1:0] lo_x, hi_x;
  logic          snd, on, snd1, off, snd2, pt;
  logic [15:0]   prev, delta;
  logic [6:0]    vel;
  logic [38:0]   prod2;
  logic          div_start, div_busy, div_done;
  logic [16:0]   div_rem, div_den;
  logic [15:0]   div_quot;
  logic [7:0]    note_full;
  logic [6:0]    note;
  logic [4:0]    chan;
  logic [1:0]    ev_cnt;
  pkmeg_pkg::event_t ev0, ev1, ev_ld;
  logic          ld, ld_last, out_free, lvl_mid;

  logic          out_valid_q, out_last_q;
  pkmeg_pkg::event_t out_ev_q;
  logic [4:0]    out_chan_q;

  assign in_idx = key_index_i[KW-1:0];
  assign key_ok = {27'd0, key_index_i} < KEY_COUNT;
  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = !(state_q == pkmeg_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.note_on     <= 16'd36045;
      cfg_q.note_off    <= 16'd29491;
      cfg_q.press_level <= 16'd52429;
      cfg_q.press_depth <= 16'd32768;
      cfg_q.velocity    <= 8'd128;
      cfg_q.press_mode  <= pkmeg_pkg::PM_OFF;
      cfg_q.channel     <= 5'd1;
      cfg_q.octave      <= 4'd2;
    end else if (cfg_we_i) begin
      case (pkmeg_pkg::reg_idx_e'(cfg_index_i))
        pkmeg_pkg::REG_NOTE_ON:     cfg_q.note_on     <= cfg_data_i;
        pkmeg_pkg::REG_NOTE_OFF:    cfg_q.note_off    <= cfg_data_i;
        pkmeg_pkg::REG_PRESS_LEVEL: cfg_q.press_level <= cfg_data_i;
        pkmeg_pkg::REG_PRESS_DEPTH: cfg_q.press_depth <= cfg_data_i;
        pkmeg_pkg::REG_VELOCITY:    cfg_q.velocity    <= cfg_data_i[7:0];
        pkmeg_pkg::REG_PRESS_MODE:  cfg_q.press_mode  <= cfg_data_i[1:0];
        pkmeg_pkg::REG_CHANNEL:     cfg_q.channel     <= cfg_data_i[4:0];
        pkmeg_pkg::REG_OCTAVE:      cfg_q.octave      <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // memories: calibration written at transfer, note state written back in EVAL
  always_ff @(posedge clk_i) begin
    if (accept && key_ok && (command_i == pkmeg_pkg::CMD_CALIB)) begin
      cal_mem[in_idx] <= {bound_low_i, bound_high_i};
    end
    if (accept) begin
      cal_rd_q  <= cal_mem[in_idx];
      note_rd_q <= note_mem[in_idx];
      idx_q     <= in_idx;
      key_q     <= key_index_i;
      v_q       <= VW'(sample_value_i);
    end
    if (state_q == pkmeg_pkg::ST_EVAL) begin
      note_mem[idx_q] <= {snd2, lvl_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_vld_q     <= '0;
      note_vld_q    <= '0;
      cal_rd_vld_q  <= 1'b0;
      note_rd_vld_q <= 1'b0;
    end else begin
      if (accept && key_ok && (command_i == pkmeg_pkg::CMD_CALIB)) cal_vld_q[in_idx] <= 1'b1;
      if (accept) begin
        cal_rd_vld_q  <= cal_vld_q[in_idx];
        note_rd_vld_q <= note_vld_q[in_idx];
      end
      if (state_q == pkmeg_pkg::ST_EVAL) note_vld_q[idx_q] <= 1'b1;
    end
  end

  always_comb begin
    lo      = cal_rd_vld_q ? cal_rd_q[21:11] : 11'd0;
    hi      = cal_rd_vld_q ? cal_rd_q[10:0]  : 11'd1024;
    lo_x    = VW'(lo);
    hi_x    = VW'(hi);
    lvl_mid = !(v_q < lo_x) && !(v_q >= hi_x);
    snd     = note_rd_vld_q && note_rd_q[16];
    prev    = note_rd_vld_q ? note_rd_q[15:0] : 16'd0;
    on      = !snd && (lvl_q > cfg_q.note_on);
    snd1    = snd || on;
    off     = snd1 && (lvl_q < cfg_q.note_off);
    snd2    = snd1 && !off;
    pt      = snd2 && (lvl_q > cfg_q.press_level) &&
              (cfg_q.press_mode == pkmeg_pkg::PM_CHANNEL ||
               cfg_q.press_mode == pkmeg_pkg::PM_POLY);
    delta   = (lvl_q > prev) ? (lvl_q - prev) : 16'd0;
    if (cfg_q.velocity == 8'd128) begin
      vel = pkmeg_pkg::VEL_TABLE[delta[15:8]];
    end else if (cfg_q.velocity > 8'd127) begin
      vel = 7'd127;
    end else begin
      vel = cfg_q.velocity[6:0];
    end
    div_start = 1'b0;
    div_rem   = 17'(v_q - lo_x);
    div_den   = 17'(hi - lo);
    if (state_q == pkmeg_pkg::ST_LVL && lvl_mid) begin
      div_start = 1'b1;
    end else if (state_q == pkmeg_pkg::ST_EVAL && pt) begin
      div_start = 1'b1;
      div_rem   = {1'b0, lvl_q - cfg_q.press_level};
      div_den   = 17'h1_0000 - {1'b0, cfg_q.press_level};
    end
    prod2 = {7'd0, prod1_q} * 39'd127;
  end

  pkmeg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .rem_i   (div_rem),
    .div_i   (div_den),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i) begin
    case (state_q)
      pkmeg_pkg::ST_LVL: begin
        if (v_q < lo_x) lvl_q <= 16'd0;
        else if (v_q >= hi_x) lvl_q <= 16'hFFFF;
      end
      pkmeg_pkg::ST_DIVL: if (div_done) lvl_q <= div_quot;
      pkmeg_pkg::ST_EVAL: begin
        on_q  <= on;
        off_q <= off;
        pt_q  <= pt;
        vel_q <= vel;
      end
      pkmeg_pkg::ST_DIVP: if (div_done) prod1_q <= div_quot * cfg_q.press_depth;
      pkmeg_pkg::ST_MULA: amt_q <= prod2[38:32];
      default: ;
    endcase
  end

  // event list and output fields
  always_comb begin
    chan = (cfg_q.channel == 5'd0) ? 5'd1 :
           (cfg_q.channel > 5'd16) ? 5'd16 : cfg_q.channel;
    note_full = {4'd0, cfg_q.octave} * 8'd12 + {3'd0, key_q};
    note = (note_full > 8'd127) ? 7'd127 : note_full[6:0];
    ev_cnt = {1'b0, on_q} + {1'b0, off_q} + {1'b0, pt_q};
    ev0.kind  = on_q ? pkmeg_pkg::EV_NOTE_ON :
                off_q ? pkmeg_pkg::EV_NOTE_OFF :
                (cfg_q.press_mode == pkmeg_pkg::PM_CHANNEL) ?
                pkmeg_pkg::EV_CHAN_PRESS : pkmeg_pkg::EV_POLY_PRESS;
    ev0.note  = (ev0.kind == pkmeg_pkg::EV_CHAN_PRESS) ? 7'd0 : note;
    ev0.value = on_q ? vel_q : off_q ? 7'd127 : amt_q;
    ev1.kind  = off_q ? pkmeg_pkg::EV_NOTE_OFF :
                (cfg_q.press_mode == pkmeg_pkg::PM_CHANNEL) ?
                pkmeg_pkg::EV_CHAN_PRESS : pkmeg_pkg::EV_POLY_PRESS;
    ev1.note  = (ev1.kind == pkmeg_pkg::EV_CHAN_PRESS) ? 7'd0 : note;
    ev1.value = off_q ? 7'd127 : amt_q;
    out_free  = !out_valid_q || !out_stall_i;
    ld        = out_free && (state_q == pkmeg_pkg::ST_EMIT0 ||
                             state_q == pkmeg_pkg::ST_EMIT1);
    ev_ld     = (state_q == pkmeg_pkg::ST_EMIT1) ? ev1 : ev0;
    ld_last   = (state_q == pkmeg_pkg::ST_EMIT1) || (ev_cnt == 2'd1);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      pkmeg_pkg::ST_IDLE: begin
        if (accept && key_ok && (command_i == pkmeg_pkg::CMD_SAMPLE)) begin
          state_d = pkmeg_pkg::ST_RD;
        end
      end
      pkmeg_pkg::ST_RD:   state_d = pkmeg_pkg::ST_LVL;
      pkmeg_pkg::ST_LVL:  state_d = lvl_mid ? pkmeg_pkg::ST_DIVL : pkmeg_pkg::ST_EVAL;
      pkmeg_pkg::ST_DIVL: if (div_done) state_d = pkmeg_pkg::ST_EVAL;
      pkmeg_pkg::ST_EVAL: begin
        if (pt) state_d = pkmeg_pkg::ST_DIVP;
        else if (on || off) state_d = pkmeg_pkg::ST_EMIT0;
        else state_d = pkmeg_pkg::ST_IDLE;
      end
      pkmeg_pkg::ST_DIVP: if (div_done) state_d = pkmeg_pkg::ST_MULA;
      pkmeg_pkg::ST_MULA: state_d = pkmeg_pkg::ST_MULB;
      pkmeg_pkg::ST_MULB: state_d = pkmeg_pkg::ST_EMIT0;
      pkmeg_pkg::ST_EMIT0: begin
        if (out_free) state_d = (ev_cnt == 2'd1) ? pkmeg_pkg::ST_IDLE : pkmeg_pkg::ST_EMIT1;
      end
      pkmeg_pkg::ST_EMIT1: if (out_free) state_d = pkmeg_pkg::ST_IDLE;
      default: state_d = pkmeg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pkmeg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ld) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld) begin
      out_ev_q   <= ev_ld;
      out_chan_q <= chan;
      out_last_q <= ld_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign event_kind_o    = out_ev_q.kind;
  assign event_channel_o = out_chan_q;
  assign note_number_o   = out_ev_q.note;
  assign event_value_o   = out_ev_q.value;
  assign last_event_o    = out_last_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state not one-hot");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == pkmeg_pkg::ST_DIVL || state_q == pkmeg_pkg::ST_DIVP))
    else $error("divider running outside a divide state");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_event_o |=> out_valid_o && last_event_o)
    else $error("second event of a sample did not follow");

endmodule

`default_nettype wire
